@@ hdl/sbb_pkg.sv @@
// Package for the sound CPU bus bridge: beat types, opcodes, route codes
// and the fixed bus map. No dependencies.
package sbb_pkg;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [2:0]  route;
    logic [23:0] ext_address;
    logic [7:0]  ext_data;
    logic        cpu_reset_pulse;
    logic        cpu_may_run;
  } rsp_t;

  // Decoded access, handed from the decoder to the top level.
  typedef struct packed {
    logic ram_we;
    logic ram_sel;
    logic bank_we;
    logic grant_we;
    logic grant_val;
    logic rst_we;
    logic rst_release;
    rsp_t rsp;
  } dec_t;

  localparam logic [1:0] OP_CPU_RD  = 2'd0;
  localparam logic [1:0] OP_CPU_WR  = 2'd1;
  localparam logic [1:0] OP_CTRL_WR = 2'd2;
  localparam logic [1:0] OP_CTRL_RD = 2'd3;

  localparam logic [2:0] ROUTE_NONE     = 3'd0;
  localparam logic [2:0] ROUTE_FM_RD    = 3'd1;
  localparam logic [2:0] ROUTE_FM_WR    = 3'd2;
  localparam logic [2:0] ROUTE_TONE_WR  = 3'd3;
  localparam logic [2:0] ROUTE_BANK_RD  = 3'd4;
  localparam logic [2:0] ROUTE_BANK_WR  = 3'd5;

  localparam logic [15:0] ADDR_FM      = 16'h4000;
  localparam logic [15:0] ADDR_UNMAP   = 16'h6000;
  localparam logic [15:0] ADDR_BANK    = 16'h6000;
  localparam logic [15:0] ADDR_TONE    = 16'h7F11;
  localparam logic [15:0] ADDR_HOST    = 16'h8000;
  localparam logic [15:0] ADDR_GRANT   = 16'h1100;
  localparam logic [15:0] ADDR_RESET   = 16'h1200;

  // Span of the RAM window before the modulo by the RAM depth.
  localparam int unsigned RAM_SPAN = 8192;

  localparam logic [7:0] OPEN_BUS = 8'hFF;

endpackage

@@ hdl/sound_cpu_bus_bridge.sv @@
// Sound CPU bus bridge top level: control registers, sound RAM and the
// result stage. Depends on sbb_pkg, sbb_decode and sbb_ram.
// done_o is registered: it is high for the cycle that follows the accepting edge.
// Throughput: one beat per cycle; busy stays low and the sound RAM port
// takes one access per cycle, so back-to-back RAM accesses never overlap.
// Reset: bank 0, bus not granted, CPU held in reset, never released;
// RAM contents are unknown until written. The receiver cannot stall.
module sound_cpu_bus_bridge #(
  parameter int unsigned RAM_DEPTH = 8192
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  sbb_pkg::req_t req_i,
  output logic          done_o,
  output sbb_pkg::rsp_t rsp_o
);

  localparam int unsigned AW = $clog2(RAM_DEPTH);

  sbb_pkg::dec_t dec;
  sbb_pkg::rsp_t rsp_q, rsp_d;
  logic [AW-1:0] ram_idx;
  logic [7:0]    ram_rdata;
  logic          accept;
  logic          done_q;
  logic          ram_sel_q;
  logic [8:0]    bank_q, bank_d;
  logic          granted_q, granted_d;
  logic          held_q, held_d;
  logic          released_q, released_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  sbb_decode #(
    .RAM_DEPTH (RAM_DEPTH),
    .AW        (AW)
  ) u_decode (
    .req_i           (req_i),
    .bank_i          (bank_q),
    .bus_granted_i   (granted_q),
    .held_in_reset_i (held_q),
    .dec_o           (dec),
    .ram_idx_o       (ram_idx)
  );

  sbb_ram #(
    .DEPTH (RAM_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (accept && (dec.ram_we || dec.ram_sel)),
    .we_i    (dec.ram_we),
    .addr_i  (ram_idx),
    .wdata_i (req_i.data),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    bank_d     = bank_q;
    granted_d  = granted_q;
    held_d     = held_q;
    released_d = released_q;
    if (dec.bank_we) begin
      bank_d = {req_i.data[0], bank_q[8:1]};
    end
    if (dec.grant_we) begin
      granted_d = dec.grant_val;
    end
    if (dec.rst_we) begin
      held_d = !dec.rst_release;
      if (dec.rst_release) begin
        released_d = 1'b1;
      end
    end
    rsp_d             = dec.rsp;
    rsp_d.cpu_may_run = released_d && !held_d && !granted_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q     <= '0;
      granted_q  <= 1'b0;
      held_q     <= 1'b1;
      released_q <= 1'b0;
      done_q     <= 1'b0;
      ram_sel_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        bank_q     <= bank_d;
        granted_q  <= granted_d;
        held_q     <= held_d;
        released_q <= released_d;
        ram_sel_q  <= dec.ram_sel;
      end
    end
  end

  // Result payload, held until the next beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  always_comb begin
    rsp_o = rsp_q;
    if (ram_sel_q) begin
      rsp_o.read_data = ram_rdata;
    end
  end

  assign done_o = done_q;

endmodule

@@ hdl/sbb_ram.sv @@
// Sound RAM: single-port synchronous memory with a registered read.
// Depends on nothing.
module sbb_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && !we_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/sbb_decode.sv @@
// Bus decoder: maps one beat to RAM access, control updates and a partial
// result. Depends on sbb_pkg.
module sbb_decode #(
  parameter int unsigned RAM_DEPTH = 8192,
  parameter int unsigned AW        = 13
) (
  input  sbb_pkg::req_t req_i,
  input  logic [8:0]    bank_i,
  input  logic          bus_granted_i,
  input  logic          held_in_reset_i,
  output sbb_pkg::dec_t dec_o,
  output logic [AW-1:0] ram_idx_o
);

  // Conditional subtracts of RAM_DEPTH << k fold the window into the RAM.
  localparam int NSTEP =
    $clog2((sbb_pkg::RAM_SPAN + RAM_DEPTH - 1) / RAM_DEPTH);

  logic [15:0] idx;

  always_comb begin
    idx = {3'b000, req_i.address[12:0]};
    for (int k = NSTEP - 1; k >= 0; k--) begin
      if (idx >= 16'(RAM_DEPTH << k)) begin
        idx = idx - 16'(RAM_DEPTH << k);
      end
    end
  end

  assign ram_idx_o = idx[AW-1:0];

  always_comb begin
    dec_o     = '0;
    case (req_i.opcode)
      sbb_pkg::OP_CPU_RD: begin
        if (req_i.address < sbb_pkg::ADDR_FM) begin
          dec_o.ram_sel = 1'b1;
        end else if (req_i.address < sbb_pkg::ADDR_UNMAP) begin
          dec_o.rsp.read_data   = sbb_pkg::OPEN_BUS;
          dec_o.rsp.route       = sbb_pkg::ROUTE_FM_RD;
          dec_o.rsp.ext_address = {22'd0, req_i.address[1:0]};
        end else if (req_i.address >= sbb_pkg::ADDR_HOST) begin
          dec_o.rsp.read_data   = sbb_pkg::OPEN_BUS;
          dec_o.rsp.route       = sbb_pkg::ROUTE_BANK_RD;
          dec_o.rsp.ext_address = {bank_i, req_i.address[14:0]};
        end else begin
          dec_o.rsp.read_data = sbb_pkg::OPEN_BUS;
        end
      end
      sbb_pkg::OP_CPU_WR: begin
        if (req_i.address < sbb_pkg::ADDR_FM) begin
          dec_o.ram_we = 1'b1;
        end else if (req_i.address < sbb_pkg::ADDR_UNMAP) begin
          dec_o.rsp.route       = sbb_pkg::ROUTE_FM_WR;
          dec_o.rsp.ext_address = {22'd0, req_i.address[1:0]};
          dec_o.rsp.ext_data    = req_i.data;
        end else if (req_i.address == sbb_pkg::ADDR_BANK) begin
          dec_o.bank_we = 1'b1;
        end else if (req_i.address == sbb_pkg::ADDR_TONE) begin
          dec_o.rsp.route    = sbb_pkg::ROUTE_TONE_WR;
          dec_o.rsp.ext_data = req_i.data;
        end else if (req_i.address >= sbb_pkg::ADDR_HOST) begin
          dec_o.rsp.route       = sbb_pkg::ROUTE_BANK_WR;
          dec_o.rsp.ext_address = {bank_i, req_i.address[14:0]};
          dec_o.rsp.ext_data    = req_i.data;
        end
      end
      sbb_pkg::OP_CTRL_WR: begin
        if (req_i.address == sbb_pkg::ADDR_GRANT) begin
          dec_o.grant_we  = 1'b1;
          dec_o.grant_val = (req_i.data != 8'd0);
        end else if (req_i.address == sbb_pkg::ADDR_RESET) begin
          dec_o.rst_we               = 1'b1;
          dec_o.rst_release          = (req_i.data != 8'd0);
          dec_o.rsp.cpu_reset_pulse  = (req_i.data != 8'd0);
        end
      end
      sbb_pkg::OP_CTRL_RD: begin
        if (req_i.address == sbb_pkg::ADDR_GRANT) begin
          dec_o.rsp.read_data = {7'd0, !bus_granted_i};
        end else if (req_i.address == sbb_pkg::ADDR_RESET) begin
          dec_o.rsp.read_data = {7'd0, held_in_reset_i};
        end
      end
      default: begin
        dec_o = '0;
      end
    endcase
  end

endmodule

@@ hdl/sbb_checker.sv @@
// Port-level checker for the sound CPU bus bridge, bound to the top level.
// Depends on sbb_pkg and sound_cpu_bus_bridge.
module sbb_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input sbb_pkg::req_t req_i,
  input logic          done_o,
  input sbb_pkg::rsp_t rsp_o
);

  // Every accepted beat yields exactly one result, in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted beat gave no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without an accepted beat");

  // Write routes never return read data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.route == sbb_pkg::ROUTE_FM_WR ||
                rsp_o.route == sbb_pkg::ROUTE_TONE_WR ||
                rsp_o.route == sbb_pkg::ROUTE_BANK_WR)) |-> (rsp_o.read_data == 8'd0))
    else $error("write route carries read data");

  // A reset pulse comes only from a reset-control write and releases the CPU
  // unless the bus is granted away.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.cpu_reset_pulse) |->
      (rsp_o.route == sbb_pkg::ROUTE_NONE && rsp_o.read_data == 8'd0 &&
       $past(req_i.opcode) == sbb_pkg::OP_CTRL_WR &&
       $past(req_i.address) == sbb_pkg::ADDR_RESET))
    else $error("reset pulse from wrong beat");

  // FM port addresses stay within two bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (rsp_o.route == sbb_pkg::ROUTE_FM_RD ||
                rsp_o.route == sbb_pkg::ROUTE_FM_WR)) |->
      (rsp_o.ext_address[23:2] == 22'd0))
    else $error("fm port address out of range");

endmodule

bind sound_cpu_bus_bridge sbb_checker u_sbb_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .req_i  (req_i),
  .done_o (done_o),
  .rsp_o  (rsp_o)
);
